@@ hdl/spq_pkg.sv @@
package spq_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Action codes
  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_DEC = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_LOWER = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pri;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

endpackage

@@ hdl/stable_priority_queue_decrease_key.sv @@
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   in_action, in_patient_id, in_priority_req
// out_     output     out_valid / out_ready out_status, out_served_id, out_head_id,
//                                           out_head_priority, out_queue_empty,
//                                           out_entry_count
//
// One transaction at a time; in_ready is high only while the sequencer is idle.
// The table has one read and one write port and the walk moves one entry per
// cycle. Reset is synchronous; the table needs no clearing.
// A result waiting on out_ready holds the sequencer in its final state.
module stable_priority_queue_decrease_key (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_patient_id,
  input  logic [15:0] in_priority_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_served_id,
  output logic [15:0] out_head_id,
  output logic [15:0] out_head_priority,
  output logic        out_queue_empty,
  output logic [6:0]  out_entry_count
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_SRCH     = 3'd3;
  localparam logic [2:0] S_REM      = 3'd4;
  localparam logic [2:0] S_FIN      = 3'd5;

  localparam int CW = spq_pkg::CNT_W;
  localparam int AW = spq_pkg::ADDR_W;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [2:0]      stat_r, stat_nxt;
  logic [15:0]     served_r, served_nxt;
  logic            reins_r, reins_nxt;
  logic [15:0]     id_r, pri_r;
  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [15:0]     out_served_r, out_head_id_r, out_head_pri_r;
  logic            out_empty_r;
  logic [6:0]      out_count_r;

  spq_pkg::tbl_wr_t wr;
  logic [AW-1:0]    rd_addr;
  spq_pkg::entry_t  rd_data;
  spq_pkg::entry_t  head;
  logic             load_out;

  spq_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .head    (head)
  );

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Sequencer: walk the table one entry per cycle
  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    cur_nxt    = cur_r;
    stat_nxt   = stat_r;
    served_nxt = served_r;
    reins_nxt  = reins_r;
    wr         = '0;
    rd_addr    = cur_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          stat_nxt   = spq_pkg::ST_OK;
          served_nxt = '0;
          reins_nxt  = 1'b0;
          state_nxt  = S_FIN;
          case (in_action)
            spq_pkg::ACT_ENQ: begin
              if (occ_r >= CW'(spq_pkg::CAPACITY)) begin
                stat_nxt = spq_pkg::ST_FULL;
              end else if (occ_r == '0) begin
                wr.en       = 1'b1;
                wr.addr     = '0;
                wr.data.id  = in_patient_id;
                wr.data.pri = in_priority_req;
                occ_nxt     = CW'(occ_r + 1'b1);
              end else begin
                cur_nxt   = CW'(occ_r - 1'b1);
                rd_addr   = AW'(occ_r - 1'b1);
                state_nxt = S_INS;
              end
            end
            spq_pkg::ACT_DEQ: begin
              if (occ_r == '0) begin
                stat_nxt = spq_pkg::ST_EMPTY;
              end else begin
                served_nxt = head.id;
                cur_nxt    = CW'(1);
                rd_addr    = AW'(1);
                state_nxt  = S_REM;
              end
            end
            spq_pkg::ACT_DEC: begin
              if (occ_r == '0) begin
                stat_nxt = spq_pkg::ST_EMPTY;
              end else begin
                cur_nxt   = '0;
                rd_addr   = '0;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_INS: begin
        // Shift larger priorities up, drop the new entry behind ties
        cur_nxt = CW'(cur_r - 1'b1);
        rd_addr = AW'(cur_r - 1'b1);
        wr.en   = 1'b1;
        wr.addr = AW'(cur_r + 1'b1);
        if (rd_data.pri > pri_r) begin
          wr.data = rd_data;
          if (cur_r == '0) begin
            state_nxt = S_INS_LAST;
          end
        end else begin
          wr.data.id  = id_r;
          wr.data.pri = pri_r;
          occ_nxt     = CW'(occ_r + 1'b1);
          state_nxt   = S_FIN;
        end
      end
      S_INS_LAST: begin
        wr.en       = 1'b1;
        wr.addr     = '0;
        wr.data.id  = id_r;
        wr.data.pri = pri_r;
        occ_nxt     = CW'(occ_r + 1'b1);
        state_nxt   = S_FIN;
      end
      S_SRCH: begin
        // Look for the first matching id from the head
        if (rd_data.id == id_r) begin
          if (rd_data.pri < pri_r) begin
            stat_nxt  = spq_pkg::ST_NOT_LOWER;
            state_nxt = S_FIN;
          end else if (cur_r == '0) begin
            wr.en       = 1'b1;
            wr.addr     = '0;
            wr.data.id  = id_r;
            wr.data.pri = pri_r;
            state_nxt   = S_FIN;
          end else begin
            cur_nxt   = CW'(cur_r + 1'b1);
            rd_addr   = AW'(cur_r + 1'b1);
            reins_nxt = 1'b1;
            state_nxt = S_REM;
          end
        end else if (CW'(cur_r + 1'b1) >= occ_r) begin
          stat_nxt  = spq_pkg::ST_NOT_FOUND;
          state_nxt = S_FIN;
        end else begin
          cur_nxt = CW'(cur_r + 1'b1);
          rd_addr = AW'(cur_r + 1'b1);
        end
      end
      S_REM: begin
        // Close the gap by moving later entries down one slot
        if (cur_r < occ_r) begin
          wr.en   = 1'b1;
          wr.addr = AW'(cur_r - 1'b1);
          wr.data = rd_data;
          cur_nxt = CW'(cur_r + 1'b1);
          rd_addr = AW'(cur_r + 1'b1);
        end else begin
          occ_nxt = CW'(occ_r - 1'b1);
          if (reins_r) begin
            cur_nxt   = CW'(occ_r - 2'd2);
            rd_addr   = AW'(occ_r - 2'd2);
            state_nxt = S_INS;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    stat_r   <= stat_nxt;
    served_r <= served_nxt;
    reins_r  <= reins_nxt;
    if (in_valid && in_ready) begin
      id_r  <= in_patient_id;
      pri_r <= in_priority_req;
    end
    if (load_out) begin
      out_status_r   <= stat_r;
      out_served_r   <= served_r;
      out_empty_r    <= (occ_r == '0);
      out_count_r    <= 7'(occ_r);
      out_head_id_r  <= (occ_r == '0) ? 16'd0 : head.id;
      out_head_pri_r <= (occ_r == '0) ? 16'd0 : head.pri;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_served_id     = out_served_r;
  assign out_head_id       = out_head_id_r;
  assign out_head_priority = out_head_pri_r;
  assign out_queue_empty   = out_empty_r;
  assign out_entry_count   = out_count_r;

endmodule

@@ hdl/spq_table.sv @@
module spq_table (
  input  logic                          clk,
  input  spq_pkg::tbl_wr_t              wr,
  input  logic [spq_pkg::ADDR_W-1:0]    rd_addr,
  output spq_pkg::entry_t               rd_data,
  output spq_pkg::entry_t               head
);

  spq_pkg::entry_t mem [spq_pkg::CAPACITY];
  spq_pkg::entry_t rd_data_r;
  spq_pkg::entry_t head_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Shadow slot zero so the head is always at hand
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == '0)) begin
      head_r <= wr.data;
    end
  end

  assign rd_data = rd_data_r;
  assign head    = head_r;

endmodule

@@ tb/stable_priority_queue_decrease_key_tb.sv @@
module stable_priority_queue_decrease_key_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Spare action code: the block must treat it as a no-op
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam int RESET_CYCLES      = 7;
  localparam int ITEMS_PER_PHASE   = 600;
  localparam int LONG_HOLD_CYCLES  = 400;
  // Long enough for the slowest decrease-key on a full table
  localparam int SETTLE_CYCLES     = 3 * spq_pkg::CAPACITY + 60;
  localparam int ID_POOL           = 24;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_id;
    logic [15:0] head_id;
    logic [15:0] head_pri;
    logic        empty;
    logic [6:0]  entry_count;
  } queue_result_t;

  typedef struct {
    logic [1:0]    act;
    logic [15:0]   id;
    logic [15:0]   pri;
    bit            known;
    queue_result_t result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = spq_pkg::ACT_ENQ;
  logic [15:0] in_patient_id = '0;
  logic [15:0] in_priority_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_served_id;
  logic [15:0] out_head_id;
  logic [15:0] out_head_priority;
  logic        out_queue_empty;
  logic [6:0]  out_entry_count;

  // Shadow copy of the sorted table
  logic [15:0] model_ids [spq_pkg::CAPACITY];
  logic [15:0] model_pris [spq_pkg::CAPACITY];
  int unsigned model_count = 0;

  queue_result_t expected_results [$];
  stim_row_t     directed_rows [$];
  int            failures = 0;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  bit            hold_request = 1'b0;
  bit            filling = 1'b1;

  stable_priority_queue_decrease_key dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_patient_id     (in_patient_id),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_served_id     (out_served_id),
    .out_head_id       (out_head_id),
    .out_head_priority (out_head_priority),
    .out_queue_empty   (out_queue_empty),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Place an entry behind every entry of lower or equal priority
  function automatic void model_insert(input logic [15:0] id, input logic [15:0] pri);
    int unsigned pos;
    pos = model_count;
    while (pos > 0 && model_pris[pos-1] > pri) begin
      model_ids[pos]  = model_ids[pos-1];
      model_pris[pos] = model_pris[pos-1];
      pos--;
    end
    model_ids[pos]  = id;
    model_pris[pos] = pri;
    model_count++;
  endfunction

  // Close the gap left by the entry at slot k
  function automatic void model_remove(input int unsigned k);
    for (int unsigned j = k; j + 1 < model_count; j++) begin
      model_ids[j]  = model_ids[j+1];
      model_pris[j] = model_pris[j+1];
    end
    model_count--;
  endfunction

  // Apply one transaction to the shadow table and return the result it yields
  function automatic queue_result_t predict_queue_step(input logic [1:0] act,
                                                       input logic [15:0] id,
                                                       input logic [15:0] pri);
    queue_result_t r;
    int unsigned   k;
    r = '0;
    r.status = spq_pkg::ST_OK;
    case (act)
      spq_pkg::ACT_ENQ: begin
        if (model_count >= spq_pkg::CAPACITY) r.status = spq_pkg::ST_FULL;
        else model_insert(id, pri);
      end
      spq_pkg::ACT_DEQ: begin
        if (model_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.served_id = model_ids[0];
          model_remove(0);
        end
      end
      spq_pkg::ACT_DEC: begin
        if (model_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          // First match from the head wins
          k = 0;
          while (k < model_count && model_ids[k] != id) k++;
          if (k == model_count) r.status = spq_pkg::ST_NOT_FOUND;
          else if (model_pris[k] < pri) r.status = spq_pkg::ST_NOT_LOWER;
          else if (k == 0) model_pris[0] = pri;
          else begin
            model_remove(k);
            model_insert(id, pri);
          end
        end
      end
      default: ;
    endcase
    if (model_count > 0) begin
      r.head_id  = model_ids[0];
      r.head_pri = model_pris[0];
      r.empty    = 1'b0;
    end else begin
      r.empty = 1'b1;
    end
    r.entry_count = 7'(model_count);
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] act, input logic [15:0] id,
                                  input logic [15:0] pri);
    stim_row_t row;
    row.act    = act;
    row.id     = id;
    row.pri    = pri;
    row.known  = 1'b0;
    row.result = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known_row(input logic [1:0] act, input logic [15:0] id,
                                        input logic [15:0] pri, input logic [2:0] status,
                                        input logic [15:0] head_id,
                                        input logic [15:0] head_pri,
                                        input logic [6:0] entry_count);
    stim_row_t row;
    row.act                = act;
    row.id                 = id;
    row.pri                = pri;
    row.known              = 1'b1;
    row.result             = '0;
    row.result.status      = status;
    row.result.head_id     = head_id;
    row.result.head_pri    = head_pri;
    row.result.empty       = (entry_count == 0);
    row.result.entry_count = entry_count;
    directed_rows.push_back(row);
  endfunction

  // Mostly a small pool so ids repeat, sometimes the full range
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, ID_POOL - 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly a few levels so ties are common, plus the extremes
  function automatic logic [15:0] pick_pri();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 16'($urandom_range(0, 7));
    if (roll < 8) return 16'($urandom_range(0, 65535));
    if (roll < 9) return 16'h0000;
    return 16'hFFFF;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
      failures++;
    end
  endtask

  // Offer one transaction; valid stays high after acceptance until the caller
  // either offers the next one in the same step or drops it
  task automatic offer_item(input logic [1:0] act, input logic [15:0] id,
                            input logic [15:0] pri, input bit known,
                            input queue_result_t typed);
    queue_result_t predicted;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_patient_id   <= id;
    in_priority_req <= pri;
    do @(posedge clk); while (!in_ready);
    predicted = predict_queue_step(act, id, pri);
    expected_results.push_back(known ? typed : predicted);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Swing the table between empty and full, with decrease-key on held ids
  // and some fully random noise mixed in
  task automatic run_random_phase(input int items);
    logic [1:0]  act;
    logic [15:0] id;
    logic [15:0] pri;
    logic [15:0] cur;
    int unsigned roll;
    int unsigned slot;
    for (int n = 0; n < items; n++) begin
      if (filling && model_count == spq_pkg::CAPACITY && $urandom_range(0, 3) == 0)
        filling = 1'b0;
      else if (!filling && model_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      id   = pick_id();
      pri  = pick_pri();
      if (roll < 8) begin
        act = 2'($urandom_range(0, 3));
        id  = 16'($urandom_range(0, 65535));
        pri = 16'($urandom_range(0, 65535));
      end else if (roll < 33) begin
        act = spq_pkg::ACT_DEC;
        if (model_count > 0 && $urandom_range(0, 9) < 8) begin
          slot = $urandom_range(0, model_count - 1);
          id   = model_ids[slot];
          cur  = model_pris[slot];
          roll = $urandom_range(0, 9);
          if (roll < 5) pri = 16'($urandom_range(0, cur));
          else if (roll < 7) pri = cur;
          else if (roll < 9 && cur != 16'hFFFF) pri = 16'($urandom_range(cur + 1, 65535));
        end
      end else if (roll < (filling ? 90 : 45)) begin
        act = spq_pkg::ACT_ENQ;
      end else begin
        act = spq_pkg::ACT_DEQ;
      end
      offer_item(act, id, pri, 1'b0, '0);
    end
  endtask

  // Check each accepted result and pick the next cycle's ready
  initial begin : result_monitor
    queue_result_t got;
    queue_result_t want;
    int            hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = {out_status, out_served_id, out_head_id, out_head_priority,
               out_queue_empty, out_entry_count};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $realtime, got);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("served_id", want.served_id, got.served_id);
          check_field("head_id", want.head_id, got.head_id);
          check_field("head_priority", want.head_pri, got.head_pri);
          check_field("queue_empty", 16'(want.empty), 16'(got.empty));
          check_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-queue cases, spare code, extremes, ties, duplicate ids,
    // every decrease-key outcome, then drain past empty
    add_known_row(spq_pkg::ACT_DEQ, 16'h0000, 16'h0000, spq_pkg::ST_EMPTY,
                  16'h0000, 16'h0000, 7'd0);
    add_known_row(spq_pkg::ACT_DEC, 16'h0005, 16'h0000, spq_pkg::ST_EMPTY,
                  16'h0000, 16'h0000, 7'd0);
    add_known_row(ACT_NOP, 16'hFFFF, 16'hFFFF, spq_pkg::ST_OK,
                  16'h0000, 16'h0000, 7'd0);
    add_known_row(spq_pkg::ACT_ENQ, 16'hFFFF, 16'hFFFF, spq_pkg::ST_OK,
                  16'hFFFF, 16'hFFFF, 7'd1);
    add_known_row(spq_pkg::ACT_ENQ, 16'h0000, 16'h0000, spq_pkg::ST_OK,
                  16'h0000, 16'h0000, 7'd2);
    add_row(spq_pkg::ACT_ENQ, 16'h0007, 16'd100);
    add_row(spq_pkg::ACT_ENQ, 16'h0008, 16'd100);
    add_row(spq_pkg::ACT_ENQ, 16'h0007, 16'd100);
    add_row(spq_pkg::ACT_ENQ, 16'h0009, 16'd0);
    add_known_row(spq_pkg::ACT_DEC, 16'd1234, 16'h0000, spq_pkg::ST_NOT_FOUND,
                  16'h0000, 16'h0000, 7'd6);
    add_known_row(spq_pkg::ACT_DEC, 16'h0008, 16'd101, spq_pkg::ST_NOT_LOWER,
                  16'h0000, 16'h0000, 7'd6);
    add_row(spq_pkg::ACT_DEC, 16'h0008, 16'd100);
    add_row(spq_pkg::ACT_DEC, 16'h0007, 16'd50);
    add_row(spq_pkg::ACT_DEC, 16'h0000, 16'h0000);
    add_row(spq_pkg::ACT_DEC, 16'h0009, 16'h0000);
    add_row(spq_pkg::ACT_DEC, 16'hFFFF, 16'h0000);
    add_row(ACT_NOP, 16'hAAAA, 16'h5555);
    repeat (6) add_row(spq_pkg::ACT_DEQ, 16'h0000, 16'h0000);
    add_known_row(spq_pkg::ACT_DEQ, 16'h0000, 16'h0000, spq_pkg::ST_EMPTY,
                  16'h0000, 16'h0000, 7'd0);

    tx_idle_pct = 11;
    rx_idle_pct = 58;
    foreach (directed_rows[i])
      offer_item(directed_rows[i].act, directed_rows[i].id, directed_rows[i].pri,
                 directed_rows[i].known, directed_rows[i].result);

    // Stall the result side for a long stretch while items keep coming
    hold_request = 1'b1;
    run_random_phase(ITEMS_PER_PHASE);
    pause_until_drained();

    tx_idle_pct = 58;
    rx_idle_pct = 11;
    run_random_phase(ITEMS_PER_PHASE);
    pause_until_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(ITEMS_PER_PHASE);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Give up well past the slowest legal run
  initial begin : watchdog
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/spq_pkg.sv
hdl/spq_table.sv
hdl/stable_priority_queue_decrease_key.sv
tb/stable_priority_queue_decrease_key_tb.sv
